/* rtl/biased_sgd_factor_update_macros.svh */
// assertion helpers for the factor update block
`ifndef BIASED_SGD_FACTOR_UPDATE_MACROS_SVH
`define BIASED_SGD_FACTOR_UPDATE_MACROS_SVH

// same-cycle implication
`define BSGD_AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsgd assertion failed");

// next-cycle implication
`define BSGD_AST_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsgd assertion failed");

`endif

/* rtl/bsgd_pkg.sv */
`default_nettype none
package bsgd_pkg;

    localparam int DW = 24;

    typedef enum logic [2:0] {
        OP_TRAIN    = 3'd0,
        OP_VALIDATE = 3'd1,
        OP_PREDICT  = 3'd2,
        OP_LOAD_UF  = 3'd3,
        OP_LOAD_IF  = 3'd4,
        OP_LOAD_UB  = 3'd5,
        OP_LOAD_IB  = 3'd6,
        OP_NOP      = 3'd7
    } t_op;

    localparam logic [2:0] CFG_STEP = 3'd0;
    localparam logic [2:0] CFG_REG  = 3'd1;
    localparam logic [2:0] CFG_GM   = 3'd2;
    localparam logic [2:0] CFG_MAX  = 3'd3;
    localparam logic [2:0] CFG_MIN  = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRAP,
        S_BASE,
        S_DOT,
        S_PRED,
        S_ERR,
        S_SQ,
        S_UPD,
        S_DRAIN,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [11:0]        user_index;
        logic [11:0]        item_index;
        logic signed [23:0] rating;
        logic [5:0]         element_index;
        logic signed [23:0] load_value;
    } t_in;

    typedef struct packed {
        logic signed [23:0] prediction;
        logic [47:0]        squared_error;
        logic [2:0]         kind;
    } t_out;

    typedef struct packed {
        logic       vld;
        logic       bias;
        logic [5:0] k;
    } t_tag;

    typedef struct packed {
        logic        bias;
        logic [15:0] step;
        logic [15:0] lambda;
    } t_lane_ctl;

endpackage
`default_nettype wire

/* rtl/bsgd_ram.sv */
`default_nettype none
module bsgd_ram #(
    parameter int DEPTH = 2,
    parameter int AW    = 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [23:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [23:0]   o_rdata
);
    import bsgd_pkg::*;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_q <= mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule
`default_nettype wire

/* rtl/bsgd_lane.sv */
`default_nettype none
module bsgd_lane (
    input  logic                 i_clk,
    input  bsgd_pkg::t_lane_ctl  i_ctl,
    input  logic signed [23:0]   i_v,
    input  logic signed [23:0]   i_other,
    input  logic signed [24:0]   i_e,
    output logic signed [23:0]   o_v
);
    import bsgd_pkg::*;

    logic signed [48:0] eo;
    logic signed [48:0] a_r;
    logic signed [40:0] lv;
    logic signed [40:0] lv_r;
    logic signed [33:0] n_a;
    logic signed [33:0] r_a;
    logic signed [25:0] r_rg;
    logic signed [23:0] r_v0;
    logic signed [34:0] d;
    logic signed [51:0] gd;
    logic signed [51:0] gd_r;
    logic signed [35:0] r_st;
    logic signed [23:0] r_v1;
    logic signed [36:0] s;
    logic signed [23:0] n_o;
    logic signed [23:0] r_o;

    // stage a: error term and decay term
    assign eo   = i_e * i_other;
    assign a_r  = (eo + 49'sd32768) >>> 16;
    assign n_a  = i_ctl.bias ? 34'(i_e) : 34'(a_r);
    assign lv   = $signed({1'b0, i_ctl.lambda}) * i_v;
    assign lv_r = (lv + 41'sd32768) >>> 16;

    // stage b: scale by step
    assign d    = 35'(r_a) - 35'(r_rg);
    assign gd   = $signed({1'b0, i_ctl.step}) * d;
    assign gd_r = (gd + 52'sd32768) >>> 16;

    // stage c: add and saturate
    assign s = 37'(r_v1) + 37'(r_st);
    always_comb begin
        if (s > 37'sd8388607) begin
            n_o = 24'sd8388607;
        end else if (s < -37'sd8388608) begin
            n_o = -24'sd8388608;
        end else begin
            n_o = 24'(s);
        end
    end

    always_ff @(posedge i_clk) begin
        r_a  <= n_a;
        r_rg <= 26'(lv_r);
        r_v0 <= i_v;
        r_st <= 36'(gd_r);
        r_v1 <= r_v0;
        r_o  <= n_o;
    end

    assign o_v = r_o;
endmodule
`default_nettype wire

/* rtl/biased_sgd_factor_update.sv */
`default_nettype none
// channel   | signals                               | transfer
// ----------+---------------------------------------+------------------------------
// command   | start, busy, i_in                     | edge with start high, busy low
// result    | o_valid, o_out                        | every cycle o_valid is high
// config    | i_cfg_valid, o_cfg_ready, i_cfg_index,| edge with valid and ready high
//           | i_cfg_data                            |
// train items run the serial dot product and the update pass, validate and predict items
// the dot product only, loads neither; both passes use one factor memory read port each
// after reset a clearing pass zeroes the bias memories,
// busy stays high during it; config writes are taken at all times
// the result strobe lasts one cycle and cannot be stalled
module biased_sgd_factor_update #(
    parameter int LATENT_DIM = 20,
    parameter int NUM_USERS  = 4096,
    parameter int NUM_ITEMS  = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  bsgd_pkg::t_in  i_in,
    output logic           o_valid,
    output bsgd_pkg::t_out o_out,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [2:0]     i_cfg_index,
    input  logic [23:0]    i_cfg_data
);
    import bsgd_pkg::*;

    localparam int UW   = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
    localparam int IW   = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
    localparam int UFD  = NUM_USERS * LATENT_DIM;
    localparam int IFD  = NUM_ITEMS * LATENT_DIM;
    localparam int UFAW = (UFD > 1) ? $clog2(UFD) : 1;
    localparam int IFAW = (IFD > 1) ? $clog2(IFD) : 1;
    localparam int KW   = $clog2(LATENT_DIM + 1);
    localparam int CLR  = (NUM_USERS > NUM_ITEMS) ? NUM_USERS : NUM_ITEMS;
    localparam int CW   = $clog2(CLR);
    localparam logic [KW-1:0] LD = KW'(LATENT_DIM);
    // reciprocal constants for the row wrap, zero when the row count is 4096 or more (the full 12-bit index range)
    localparam logic [23:0] UMUL = (NUM_USERS < 4096) ? 24'(16777216 / NUM_USERS + 1) : 24'd0;
    localparam logic [23:0] IMUL = (NUM_ITEMS < 4096) ? 24'(16777216 / NUM_ITEMS + 1) : 24'd0;
    localparam logic [11:0] UMOD = (NUM_USERS < 4096) ? 12'(NUM_USERS) : 12'd0;
    localparam logic [11:0] IMOD = (NUM_ITEMS < 4096) ? 12'(NUM_ITEMS) : 12'd0;

    t_state              r_state, n_state;
    t_in                 r_in;
    logic [11:0]         r_uw, r_iw;
    logic [11:0]         r_uq, r_iq;
    logic                r_bit;
    logic [UW-1:0]       r_u;
    logic [IW-1:0]       r_i;
    logic [UFAW-1:0]     r_ub;
    logic [IFAW-1:0]     r_ib;
    logic [KW-1:0]       r_cnt;
    logic [CW-1:0]       r_clr;
    logic                r_dv, r_pv;
    logic signed [47:0]  r_prod;
    logic signed [53:0]  r_acc;
    logic signed [23:0]  r_pred;
    logic signed [24:0]  r_e;
    t_tag                r_t1, r_t2, r_t3, r_t4;
    logic [15:0]         r_step, r_lambda;
    logic signed [23:0]  r_gm, r_max, r_min;
    logic                r_ovalid;
    t_out                r_out;

    logic [35:0]         uq_full, iq_full;
    logic [23:0]         uq_back, iq_back;
    logic signed [53:0]  acc_r;
    logic signed [39:0]  sum;
    logic signed [39:0]  lim;
    logic signed [23:0]  n_pred;
    logic signed [49:0]  sq;
    logic [47:0]         sq_sat;
    logic                el_ok;

    logic                uf_we, if_we, ub_we, ib_we;
    logic [UFAW-1:0]     uf_wa, uf_ra;
    logic [IFAW-1:0]     if_wa, if_ra;
    logic [UW-1:0]       ub_wa;
    logic [IW-1:0]       ib_wa;
    logic [23:0]         uf_wd, if_wd, ub_wd, ib_wd;
    logic [23:0]         ufq, ifq, ubq, ibq;
    logic signed [23:0]  lu_v, li_v, lu_o, li_o;
    t_lane_ctl           lane_ctl;

    bsgd_ram #(.DEPTH(UFD), .AW(UFAW)) u_uf (
        .i_clk(i_clk), .i_we(uf_we), .i_waddr(uf_wa), .i_wdata(uf_wd),
        .i_raddr(uf_ra), .o_rdata(ufq)
    );
    bsgd_ram #(.DEPTH(IFD), .AW(IFAW)) u_if (
        .i_clk(i_clk), .i_we(if_we), .i_waddr(if_wa), .i_wdata(if_wd),
        .i_raddr(if_ra), .o_rdata(ifq)
    );
    bsgd_ram #(.DEPTH(NUM_USERS), .AW(UW)) u_ub (
        .i_clk(i_clk), .i_we(ub_we), .i_waddr(ub_wa), .i_wdata(ub_wd),
        .i_raddr(r_u), .o_rdata(ubq)
    );
    bsgd_ram #(.DEPTH(NUM_ITEMS), .AW(IW)) u_ib (
        .i_clk(i_clk), .i_we(ib_we), .i_waddr(ib_wa), .i_wdata(ib_wd),
        .i_raddr(r_i), .o_rdata(ibq)
    );

    assign lane_ctl.bias   = r_t1.bias;
    assign lane_ctl.step   = r_step;
    assign lane_ctl.lambda = r_lambda;
    assign lu_v = r_t1.bias ? $signed(ubq) : $signed(ufq);
    assign li_v = r_t1.bias ? $signed(ibq) : $signed(ifq);

    bsgd_lane u_lane_u (
        .i_clk(i_clk), .i_ctl(lane_ctl), .i_v(lu_v), .i_other($signed(ifq)),
        .i_e(r_e), .o_v(lu_o)
    );
    bsgd_lane u_lane_i (
        .i_clk(i_clk), .i_ctl(lane_ctl), .i_v(li_v), .i_other($signed(ufq)),
        .i_e(r_e), .o_v(li_o)
    );

    // row index reduction and prediction datapath
    assign uq_full = 36'(r_uw) * 36'(UMUL);
    assign iq_full = 36'(r_iw) * 36'(IMUL);
    assign uq_back = 24'(r_uq) * 24'(UMOD);
    assign iq_back = 24'(r_iq) * 24'(IMOD);
    assign acc_r = (r_acc + 54'sd32768) >>> 16;
    assign sum   = 40'(r_gm) + 40'($signed(ubq)) + 40'($signed(ibq)) + 40'(acc_r);
    assign sq    = r_e * r_e;
    assign el_ok = 7'(r_in.element_index) < 7'(LATENT_DIM);
    assign uf_ra = r_ub + UFAW'(r_cnt);
    assign if_ra = r_ib + IFAW'(r_cnt);

    always_comb begin
        if (sum > 40'(r_max)) begin
            lim = 40'(r_max);
        end else begin
            lim = sum;
        end
        if (lim < 40'(r_min)) begin
            n_pred = r_min;
        end else begin
            n_pred = 24'(lim);
        end
    end

    always_comb begin
        if (sq > 50'sh0FFFFFFFFFFFF) begin
            sq_sat = '1;
        end else begin
            sq_sat = 48'(sq);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == CW'(CLR - 1)) n_state = S_IDLE;
            S_IDLE:  if (start) n_state = S_WRAP;
            S_WRAP:  if (!r_bit) n_state = S_BASE;
            S_BASE: begin
                if (r_in.opcode inside {OP_TRAIN, OP_VALIDATE, OP_PREDICT}) begin
                    n_state = S_DOT;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_DOT:   if (r_cnt == LD && !r_dv && !r_pv) n_state = S_PRED;
            S_PRED:  n_state = S_ERR;
            S_ERR:   n_state = S_SQ;
            S_SQ:    n_state = (r_in.opcode == OP_TRAIN) ? S_UPD : S_IDLE;
            S_UPD:   if (r_cnt == LD) n_state = S_DRAIN;
            S_DRAIN: if (!(r_t1.vld || r_t2.vld || r_t3.vld || r_t4.vld)) n_state = S_IDLE;
            S_LOAD:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy  = (r_state != S_IDLE);
        uf_we = 1'b0;
        uf_wa = r_ub + UFAW'(r_t4.k);
        uf_wd = lu_o;
        if_we = 1'b0;
        if_wa = r_ib + IFAW'(r_t4.k);
        if_wd = li_o;
        ub_we = 1'b0;
        ub_wa = r_u;
        ub_wd = lu_o;
        ib_we = 1'b0;
        ib_wa = r_i;
        ib_wd = li_o;
        case (r_state)
            S_CLEAR: begin
                ub_we = (CW + 1)'(r_clr) < (CW + 1)'(NUM_USERS);
                ub_wa = UW'(r_clr);
                ub_wd = '0;
                ib_we = (CW + 1)'(r_clr) < (CW + 1)'(NUM_ITEMS);
                ib_wa = IW'(r_clr);
                ib_wd = '0;
            end
            S_LOAD: begin
                uf_wa = r_ub + UFAW'(r_in.element_index);
                if_wa = r_ib + IFAW'(r_in.element_index);
                uf_wd = r_in.load_value;
                if_wd = r_in.load_value;
                ub_wd = r_in.load_value;
                ib_wd = r_in.load_value;
                uf_we = (r_in.opcode == OP_LOAD_UF) && el_ok;
                if_we = (r_in.opcode == OP_LOAD_IF) && el_ok;
                ub_we = (r_in.opcode == OP_LOAD_UB);
                ib_we = (r_in.opcode == OP_LOAD_IB);
            end
            default: begin
                uf_we = r_t4.vld && !r_t4.bias;
                if_we = r_t4.vld && !r_t4.bias;
                ub_we = r_t4.vld && r_t4.bias;
                ib_we = r_t4.vld && r_t4.bias;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_dv     <= 1'b0;
            r_pv     <= 1'b0;
            r_t1     <= '0;
            r_t2     <= '0;
            r_t3     <= '0;
            r_t4     <= '0;
            r_step   <= 16'd66;
            r_lambda <= 16'd66;
            r_gm     <= 24'sd0;
            r_max    <= 24'sd8388607;
            r_min    <= 24'sd0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= 1'b0;
            r_t1.vld <= 1'b0;
            r_t2     <= r_t1;
            r_t3     <= r_t2;
            r_t4     <= r_t3;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_STEP: r_step   <= i_cfg_data[15:0];
                    CFG_REG:  r_lambda <= i_cfg_data[15:0];
                    CFG_GM:   r_gm     <= i_cfg_data;
                    CFG_MAX:  r_max    <= i_cfg_data;
                    CFG_MIN:  r_min    <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: begin
                    if (start) begin
                        r_in  <= i_in;
                        r_uw  <= i_in.user_index;
                        r_iw  <= i_in.item_index;
                        r_bit <= 1'b1;
                    end
                end
                S_WRAP: begin
                    // quotient by reciprocal multiply, then subtract it back out
                    if (r_bit) begin
                        r_uq <= uq_full[35:24];
                        r_iq <= iq_full[35:24];
                    end else begin
                        r_uw <= r_uw - uq_back[11:0];
                        r_iw <= r_iw - iq_back[11:0];
                    end
                    r_bit <= 1'b0;
                end
                S_BASE: begin
                    r_u   <= UW'(r_uw);
                    r_i   <= IW'(r_iw);
                    r_ub  <= UFAW'(r_uw) * UFAW'(LATENT_DIM);
                    r_ib  <= IFAW'(r_iw) * IFAW'(LATENT_DIM);
                    r_cnt <= '0;
                    r_acc <= '0;
                    r_dv  <= 1'b0;
                    r_pv  <= 1'b0;
                end
                S_DOT: begin
                    if (r_cnt < LD) begin
                        r_cnt <= r_cnt + 1'b1;
                        r_dv  <= 1'b1;
                    end else begin
                        r_dv <= 1'b0;
                    end
                    r_pv   <= r_dv;
                    r_prod <= $signed(ufq) * $signed(ifq);
                    if (r_pv) r_acc <= r_acc + 54'(r_prod);
                end
                S_PRED: r_pred <= n_pred;
                S_ERR:  r_e    <= 25'(r_in.rating) - 25'(r_pred);
                S_SQ: begin
                    r_ovalid               <= 1'b1;
                    r_out.prediction       <= r_pred;
                    r_out.squared_error    <= sq_sat;
                    r_out.kind             <= r_in.opcode;
                    r_cnt                  <= '0;
                end
                S_UPD: begin
                    r_t1.vld  <= 1'b1;
                    r_t1.bias <= (r_cnt == LD);
                    r_t1.k    <= 6'(r_cnt);
                    if (r_cnt < LD) r_cnt <= r_cnt + 1'b1;
                end
                S_LOAD: begin
                    r_ovalid            <= 1'b1;
                    r_out.prediction    <= '0;
                    r_out.squared_error <= '0;
                    r_out.kind          <= r_in.opcode;
                end
                default: ;
            endcase
        end
    end

    assign o_valid     = r_ovalid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;
endmodule
`default_nettype wire

/* rtl/bsgd_chk.sv */
`default_nettype none
`include "biased_sgd_factor_update_macros.svh"
module bsgd_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_valid,
    input bsgd_pkg::t_out o_out
);
    import bsgd_pkg::*;

    `BSGD_AST_IMP(a_res_busy, i_clk, i_rst_n, o_valid, $past(busy))
    `BSGD_AST_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `BSGD_AST_IMP(a_load_zero, i_clk, i_rst_n, o_valid && (o_out.kind == OP_LOAD_UF || o_out.kind == OP_LOAD_IF || o_out.kind == OP_LOAD_UB || o_out.kind == OP_LOAD_IB || o_out.kind == OP_NOP), o_out.prediction == 24'sd0 && o_out.squared_error == 48'd0)
    `BSGD_AST_NXT(a_single, i_clk, i_rst_n, o_valid, !o_valid)
    `BSGD_AST_NXT(a_idle_quiet, i_clk, i_rst_n, !busy && !start, !o_valid)
endmodule

bind biased_sgd_factor_update bsgd_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_out(o_out)
);
`default_nettype wire
